### sv/x64ep_pkg.sv
// ----------------------------------------------------------------------------
// x64ep_pkg - shared types and decode helpers for the x64 epilog recogniser
// Opcode constants, parse state, result kinds and the per-byte decode step.
// ----------------------------------------------------------------------------
package x64ep_pkg;

  localparam int unsigned WINDOW_BYTES_DEFAULT = 256;
  localparam int unsigned CFG_INDEX_W          = 2;
  localparam int unsigned CFG_DATA_W           = 32;

  typedef enum logic [1:0] {
    CFG_WINDOW_OFFSET  = 2'd0,
    CFG_FUNCTION_FIRST = 2'd1,
    CFG_FUNCTION_END   = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_HEAD  = 3'd0,
    PH_OP    = 3'd1,
    PH_REXED = 3'd2,
    PH_SKIP  = 3'd3,
    PH_DISP  = 3'd4,
    PH_REP   = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    KIND_RET        = 3'd0,
    KIND_REP_RET    = 3'd1,
    KIND_TAIL_JUMP  = 3'd2,
    KIND_REJECTED   = 3'd3,
    KIND_WINDOW_END = 3'd4
  } end_kind_t;

  localparam logic [7:0] REX_W         = 8'h48;
  localparam logic [7:0] REX_W_MASK    = 8'hF8;
  localparam logic [3:0] REX_HI        = 4'h4;
  localparam logic [7:0] OPC_ADD_IMM32 = 8'h81;
  localparam logic [7:0] OPC_ADD_IMM8  = 8'h83;
  localparam logic [7:0] OPC_LEA       = 8'h8D;
  localparam logic [7:0] MODRM_RSP     = 8'hC4;
  localparam logic [7:0] OPC_POP_FIRST = 8'h58;
  localparam logic [7:0] OPC_POP_LAST  = 8'h5F;
  localparam logic [7:0] OPC_RET       = 8'hC3;
  localparam logic [7:0] OPC_RET_IMM   = 8'hC2;
  localparam logic [7:0] OPC_JMP_REL32 = 8'hE9;
  localparam logic [7:0] OPC_REP       = 8'hF3;
  localparam logic [2:0] REG_RSP       = 3'd4;
  localparam logic [1:0] MOD_DISP8     = 2'd1;
  localparam logic [1:0] MOD_DISP32    = 2'd2;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  skip;
    logic [31:0] disp;
    logic [1:0]  disp_count;
  } parse_t;

  typedef struct packed {
    parse_t    st;
    logic      decided;
    end_kind_t kind;
    logic      disp_done;
  } step_t;

  localparam parse_t PARSE_CLEAR = '{phase: PH_HEAD, skip: 2'd0, disp: 32'd0,
                                     disp_count: 2'd0};

  function automatic step_t classify_byte(parse_t st, logic [7:0] b);
    step_t r;
    r.st        = st;
    r.decided   = 1'b0;
    r.kind      = KIND_REJECTED;
    r.disp_done = 1'b0;
    if (b >= OPC_POP_FIRST && b <= OPC_POP_LAST) begin
      r.st.phase = PH_OP;
    end else if (b == OPC_RET_IMM || b == OPC_RET) begin
      r.decided = 1'b1;
      r.kind    = KIND_RET;
    end else if (b == OPC_JMP_REL32) begin
      r.st.phase      = PH_DISP;
      r.st.disp       = 32'd0;
      r.st.disp_count = 2'd0;
    end else if (b == OPC_REP) begin
      r.st.phase = PH_REP;
    end else begin
      r.decided = 1'b1;
    end
    return r;
  endfunction

  function automatic step_t feed_byte(parse_t st, logic [7:0] b);
    step_t r;
    r.st        = st;
    r.decided   = 1'b0;
    r.kind      = KIND_REJECTED;
    r.disp_done = 1'b0;
    case (st.phase)
      PH_SKIP: begin
        if (st.skip != 2'd0) r.st.skip = st.skip - 2'd1;
        if (r.st.skip == 2'd0) r.st.phase = PH_OP;
      end
      PH_OP: begin
        if (b[7:4] == REX_HI) r.st.phase = PH_REXED;
        else r = classify_byte(st, b);
      end
      PH_REXED: r = classify_byte(st, b);
      PH_DISP: begin
        r.st.disp[{st.disp_count, 3'b000} +: 8] = b;
        if (st.disp_count == 2'd3) begin
          r.decided   = 1'b1;
          r.disp_done = 1'b1;
        end else begin
          r.st.disp_count = st.disp_count + 2'd1;
        end
      end
      PH_REP: begin
        r.decided = 1'b1;
        r.kind    = (b == OPC_RET) ? KIND_REP_RET : KIND_REJECTED;
      end
      default: r.decided = 1'b1;
    endcase
    return r;
  endfunction

endpackage

### sv/x64_epilog_recognizer.sv
// ----------------------------------------------------------------------------
// x64_epilog_recognizer - x64 epilog recogniser over a stream of code bytes
// The verdict request is registered and valid in the cycle after its deciding byte.
// Throughput: one code byte per cycle, decoded combinationally into the result
// register; a stalled result holds off code bytes.
// Reset: synchronous, clears registers, parse state and the result valid.
// ----------------------------------------------------------------------------
module x64_epilog_recognizer #(
  parameter int unsigned WINDOW_BYTES = x64ep_pkg::WINDOW_BYTES_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [x64ep_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [x64ep_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               code_valid,
  output logic                               code_stall,
  input  logic [7:0]                         code_byte,
  input  logic                               last_byte,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic                               epilog_match,
  output logic [2:0]                         end_kind,
  output logic [8:0]                         end_offset
);
  import x64ep_pkg::*;

  localparam int unsigned POS_W = $clog2(WINDOW_BYTES + 1);

  logic [31:0]      window_offset;
  logic [31:0]      function_first;
  logic [31:0]      function_end;
  parse_t           parse;
  logic [POS_W-1:0] pos;
  logic [23:0]      head_bytes;
  logic             verdict_given;

  logic             accept;
  logic [POS_W:0]   past;
  logic [POS_W-1:0] pos_next;
  logic [7:0]       b0, b1, b2;
  logic             head_keep, head_skip7, head_skip4;
  step_t            head_chain;
  logic [2:0]       head_chain_end;
  step_t            main_step;
  logic [32:0]      past_abs;
  logic [34:0]      target;
  logic             jump_leaves, jump_ends;
  logic             step_decided;
  end_kind_t        step_kind;
  logic [8:0]       step_end;
  parse_t           parse_next;
  logic [23:0]      head_next;
  logic             emit;

  assign code_stall = result_valid && result_stall;
  assign accept     = code_valid && !code_stall;
  assign past       = {1'b0, pos} + (POS_W+1)'(1);
  assign pos_next   = (pos < POS_W'(WINDOW_BYTES)) ? pos + POS_W'(1) : pos;

  assign b0 = head_bytes[7:0];
  assign b1 = head_bytes[15:8];
  assign b2 = head_bytes[23:16];

  // stack-pointer adjustment at the head of the window
  always_comb begin
    head_keep  = 1'b1;
    head_skip7 = 1'b0;
    head_skip4 = 1'b0;
    if ((b0 & REX_W_MASK) == REX_W) begin
      if (b1 == OPC_ADD_IMM32 || b1 == OPC_ADD_IMM8) begin
        if (b0 == REX_W && b2 == MODRM_RSP) begin
          if (b1 == OPC_ADD_IMM32) head_skip7 = 1'b1;
          else head_skip4 = 1'b1;
        end else begin
          head_keep = 1'b0;
        end
      end else if (b1 == OPC_LEA) begin
        if (b0[2:1] == 2'b00 && b2[5:3] == REG_RSP && b2[2:0] != REG_RSP &&
            (b2[7:6] == MOD_DISP8 || b2[7:6] == MOD_DISP32)) begin
          if (b2[7:6] == MOD_DISP8) head_skip4 = 1'b1;
          else head_skip7 = 1'b1;
        end else begin
          head_keep = 1'b0;
        end
      end
    end
  end

  // no adjustment: the four head bytes are decoded as ordinary code
  always_comb begin
    logic [7:0] chain_byte;
    chain_byte           = 8'd0;
    head_chain.st        = parse;
    head_chain.st.phase  = PH_OP;
    head_chain.decided   = 1'b0;
    head_chain.kind      = KIND_REJECTED;
    head_chain.disp_done = 1'b0;
    head_chain_end       = 3'd4;
    for (int i = 0; i < 4; i++) begin
      if (!head_chain.decided) begin
        chain_byte     = (i < 3) ? head_bytes[8*i +: 8] : code_byte;
        head_chain     = feed_byte(head_chain.st, chain_byte);
        head_chain_end = 3'(i + 1);
      end
    end
  end

  assign main_step = feed_byte(parse, code_byte);

  // tail jump target, 35-bit signed so a wrap shows as negative
  assign past_abs    = {1'b0, window_offset} + 33'(past);
  assign target      = {2'b00, past_abs} + {{3{main_step.st.disp[31]}}, main_step.st.disp};
  assign jump_leaves = target[34] || (target[33:0] < {2'b00, function_first}) ||
                       (target[33:0] >= {2'b00, function_end});
  assign jump_ends   = past_abs == {1'b0, function_end};

  always_comb begin
    parse_next   = parse;
    head_next    = head_bytes;
    step_decided = 1'b0;
    step_kind    = KIND_REJECTED;
    step_end     = 9'(past);
    if (parse.phase == PH_HEAD) begin
      if (pos < POS_W'(3)) begin
        head_next[{pos[1:0], 3'b000} +: 8] = code_byte;
      end else if (!head_keep) begin
        step_decided = 1'b1;
      end else if (head_skip7) begin
        parse_next.phase = PH_SKIP;
        parse_next.skip  = 2'd3;
      end else if (head_skip4) begin
        parse_next.phase = PH_OP;
      end else begin
        parse_next   = head_chain.st;
        step_decided = head_chain.decided;
        step_kind    = head_chain.kind;
        step_end     = 9'(head_chain_end);
      end
    end else begin
      parse_next   = main_step.st;
      step_decided = main_step.decided;
      if (main_step.disp_done) begin
        step_kind = (jump_leaves && jump_ends) ? KIND_TAIL_JUMP : KIND_REJECTED;
      end else begin
        step_kind = main_step.kind;
      end
    end
    emit = step_decided || last_byte || (past >= (POS_W+1)'(WINDOW_BYTES));
    if (!step_decided) begin
      step_kind = KIND_WINDOW_END;
      step_end  = 9'(past);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_offset  <= 32'd0;
      function_first <= 32'd0;
      function_end   <= 32'd0;
      parse          <= PARSE_CLEAR;
      pos            <= '0;
      head_bytes     <= 24'd0;
      verdict_given  <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_WINDOW_OFFSET:  window_offset  <= cfg_data;
          CFG_FUNCTION_FIRST: function_first <= cfg_data;
          CFG_FUNCTION_END:   function_end   <= cfg_data;
          default: ;
        endcase
      end
      if (result_valid && !result_stall) result_valid <= 1'b0;
      if (accept) begin
        if (verdict_given) begin
          if (last_byte) begin
            parse         <= PARSE_CLEAR;
            pos           <= '0;
            head_bytes    <= 24'd0;
            verdict_given <= 1'b0;
          end
        end else if (emit) begin
          result_valid <= 1'b1;
          if (last_byte) begin
            parse      <= PARSE_CLEAR;
            pos        <= '0;
            head_bytes <= 24'd0;
          end else begin
            verdict_given <= 1'b1;
          end
        end else begin
          parse      <= parse_next;
          pos        <= pos_next;
          head_bytes <= head_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !verdict_given && emit) begin
      epilog_match <= (step_kind == KIND_RET) || (step_kind == KIND_REP_RET) ||
                      (step_kind == KIND_TAIL_JUMP);
      end_kind     <= step_kind;
      end_offset   <= step_end;
    end
  end

endmodule

### sv/x64ep_checker.sv
// ----------------------------------------------------------------------------
// x64ep_checker - port-level checks for the x64 epilog recogniser
// Result hold under stall, flow control and result consistency.
// ----------------------------------------------------------------------------
module x64ep_checker (
  input logic       clk,
  input logic       rst,
  input logic       code_valid,
  input logic       code_stall,
  input logic       result_valid,
  input logic       result_stall,
  input logic       epilog_match,
  input logic [2:0] end_kind,
  input logic [8:0] end_offset
);
  import x64ep_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(epilog_match) &&
      $stable(end_kind) && $stable(end_offset))
    else $error("stalled result request changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !code_stall)
    else $error("code stalled with empty result register");

  a_epilog_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> epilog_match == (end_kind == KIND_RET || end_kind == KIND_REP_RET ||
      end_kind == KIND_TAIL_JUMP))
    else $error("epilog_match disagrees with end_kind");

  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid && !$past(result_valid) |-> $past(code_valid && !code_stall))
    else $error("result request without a code byte");

endmodule

bind x64_epilog_recognizer x64ep_checker u_checker (.*);

### bench/epilog_tracker_pkg.sv
// ----------------------------------------------------------------------------
// epilog_tracker_pkg - verdict tracking for the x64 epilog recogniser bench
// Holds a bit-level model of the byte parser, its own copy of the three
// registers and the queue of verdicts still due from the block.
// ----------------------------------------------------------------------------
package epilog_tracker_pkg;
  import x64ep_pkg::*;

  class epilog_tracker;
    typedef struct {
      logic        is_epi;
      end_kind_t   kind;
      logic [8:0]  offs;
    } verdict_t;

    verdict_t    verdicts_due[$];
    logic [31:0] reg_window;
    logic [31:0] reg_func_first;
    logic [31:0] reg_func_end;
    int unsigned window_limit;

    phase_t      stage;
    int unsigned at_byte;
    logic [23:0] prefix;
    int unsigned skip_left;
    logic [31:0] rel32;
    int unsigned rel32_count;
    bit          settled;

    int unsigned errors;
    int unsigned decoded_bytes;
    int unsigned kind_seen[5];

    function new(int unsigned limit);
      window_limit   = limit;
      reg_window     = '0;
      reg_func_first = '0;
      reg_func_end   = '0;
      errors         = 0;
      decoded_bytes  = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      clear_window();
    endfunction

    function void set_register(cfg_reg_t idx, logic [31:0] value);
      case (idx)
        CFG_WINDOW_OFFSET:  reg_window     = value;
        CFG_FUNCTION_FIRST: reg_func_first = value;
        CFG_FUNCTION_END:   reg_func_end   = value;
        default: ;
      endcase
    endfunction

    function void clear_window();
      stage       = PH_HEAD;
      at_byte     = 0;
      prefix      = '0;
      skip_left   = 0;
      rel32       = '0;
      rel32_count = 0;
      settled     = 0;
    endfunction

    function bit decode_opcode(logic [7:0] b, int unsigned p, output end_kind_t k,
                               output logic [8:0] eo);
      k  = KIND_REJECTED;
      eo = 9'(p + 1);
      if (b >= OPC_POP_FIRST && b <= OPC_POP_LAST) begin
        stage = PH_OP;
        return 1'b0;
      end
      if (b == OPC_RET || b == OPC_RET_IMM) begin
        k = KIND_RET;
        return 1'b1;
      end
      if (b == OPC_JMP_REL32) begin
        stage       = PH_DISP;
        rel32       = '0;
        rel32_count = 0;
        return 1'b0;
      end
      if (b == OPC_REP) begin
        stage = PH_REP;
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function bit decode_byte(logic [7:0] b, int unsigned p, output end_kind_t k,
                             output logic [8:0] eo);
      logic [63:0] past;
      logic [63:0] sdisp;
      logic [63:0] target;
      k  = KIND_REJECTED;
      eo = 9'(p + 1);
      case (stage)
        PH_SKIP: begin
          if (skip_left > 0) skip_left--;
          if (skip_left == 0) stage = PH_OP;
          return 1'b0;
        end
        PH_OP: begin
          if (b[7:4] == REX_HI) begin
            stage = PH_REXED;
            return 1'b0;
          end
          return decode_opcode(b, p, k, eo);
        end
        PH_REXED: return decode_opcode(b, p, k, eo);
        PH_DISP: begin
          rel32[8*rel32_count +: 8] = b;
          if (rel32_count == 3) begin
            past   = 64'(p) + 64'd1;
            sdisp  = {{32{rel32[31]}}, rel32};
            target = 64'(reg_window) + past + sdisp;
            if ((target < 64'(reg_func_first) || target >= 64'(reg_func_end)) &&
                64'(reg_window) + past == 64'(reg_func_end))
              k = KIND_TAIL_JUMP;
            return 1'b1;
          end
          rel32_count++;
          return 1'b0;
        end
        PH_REP: begin
          if (b == OPC_RET) k = KIND_REP_RET;
          return 1'b1;
        end
        default: return 1'b1;
      endcase
    endfunction

    // stack adjustment check on the first four bytes
    function bit decode_head(logic [7:0] b, int unsigned p, output end_kind_t k,
                             output logic [8:0] eo);
      logic [7:0]  b0;
      logic [7:0]  b1;
      logic [7:0]  b2;
      logic [1:0]  mod;
      int unsigned skip;
      bit          keep;
      k  = KIND_REJECTED;
      eo = 9'(p + 1);
      if (p < 3) begin
        prefix[8*p +: 8] = b;
        return 1'b0;
      end
      b0   = prefix[7:0];
      b1   = prefix[15:8];
      b2   = prefix[23:16];
      mod  = b2[7:6];
      skip = 0;
      keep = 1;
      if ((b0 & REX_W_MASK) == REX_W) begin
        if (b1 == OPC_ADD_IMM32 || b1 == OPC_ADD_IMM8) begin
          if (b0 == REX_W && b2 == MODRM_RSP) skip = (b1 == OPC_ADD_IMM32) ? 7 : 4;
          else keep = 0;
        end else if (b1 == OPC_LEA) begin
          if (b0[2:1] == 2'b00 && b2[5:3] == REG_RSP && b2[2:0] != REG_RSP &&
              (mod == MOD_DISP8 || mod == MOD_DISP32))
            skip = (mod == MOD_DISP8) ? 4 : 7;
          else keep = 0;
        end
      end
      if (!keep) begin
        eo = 9'd4;
        return 1'b1;
      end
      if (skip == 7) begin
        stage     = PH_SKIP;
        skip_left = 3;
        return 1'b0;
      end
      stage = PH_OP;
      if (skip == 4) return 1'b0;
      for (int i = 0; i < 4; i++) begin
        if (decode_byte((i < 3) ? prefix[8*i +: 8] : b, i, k, eo)) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      end_kind_t   k;
      logic [8:0]  eo;
      bit          got;
      verdict_t    v;
      int unsigned p;
      if (settled) begin
        if (last) clear_window();
        return;
      end
      decoded_bytes++;
      p = at_byte;
      if (stage == PH_HEAD) got = decode_head(b, p, k, eo);
      else got = decode_byte(b, p, k, eo);
      if (at_byte < window_limit) at_byte++;
      if (!got) begin
        if (!last && p + 1 < window_limit) return;
        k  = KIND_WINDOW_END;
        eo = 9'(p + 1);
      end
      v.is_epi = (k == KIND_RET || k == KIND_REP_RET || k == KIND_TAIL_JUMP);
      v.kind   = k;
      v.offs   = eo;
      verdicts_due.push_back(v);
      if (last) clear_window();
      else settled = 1;
    endfunction

    function void match_verdict(logic epi, logic [2:0] kind, logic [8:0] offs);
      verdict_t v;
      if (verdicts_due.size() == 0) begin
        $error("verdict with none due: epilog_match=%0d end_kind=%0d end_offset=%0d",
               epi, kind, offs);
        errors++;
        return;
      end
      v = verdicts_due.pop_front();
      kind_seen[int'(v.kind)]++;
      if (epi !== v.is_epi) begin
        $error("epilog_match: expected %0d, got %0d", v.is_epi, epi);
        errors++;
      end
      if (kind !== v.kind) begin
        $error("end_kind: expected %0d, got %0d", v.kind, kind);
        errors++;
      end
      if (offs !== v.offs) begin
        $error("end_offset: expected %0d, got %0d", v.offs, offs);
        errors++;
      end
    endfunction
  endclass

endpackage

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench - self-checking bench for x64_epilog_recognizer
// Streams code windows (directed, then well-formed epilogs with random
// content, truncations and noise) under several register settings, with
// bursty code requests and patterned result stalls, and checks each verdict.
// ----------------------------------------------------------------------------
module testbench;
  import x64ep_pkg::*;
  import epilog_tracker_pkg::*;

  localparam int unsigned WIN_BYTES = x64ep_pkg::WINDOW_BYTES_DEFAULT;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  cfg_write    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  code_valid   = 1'b0;
  logic                  code_stall;
  logic [7:0]            code_byte    = '0;
  logic                  last_byte    = 1'b0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic                  epilog_match;
  logic [2:0]            end_kind;
  logic [8:0]            end_offset;

  epilog_tracker tracker;
  logic [7:0]    win_bytes[$];
  bit            gaps_on      = 1'b1;
  int unsigned   burst_left   = 0;
  int unsigned   windows_sent = 0;
  int unsigned   bytes_sent   = 0;
  int unsigned   settings     = 0;
  int unsigned   jump_span    = 8;
  int unsigned   stall_mode   = 0;
  int unsigned   mode_left    = 0;

  x64_epilog_recognizer #(.WINDOW_BYTES(WIN_BYTES)) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .code_valid   (code_valid),
    .code_stall   (code_stall),
    .code_byte    (code_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .epilog_match (epilog_match),
    .end_kind     (end_kind),
    .end_offset   (end_offset)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 99) < 30);
      2: result_stall <= ($urandom_range(0, 99) < 70);
      default: result_stall <= ~result_stall;
    endcase
  end

  always @(negedge clk) begin
    if (!rst && result_valid && !result_stall)
      tracker.match_verdict(epilog_match, end_kind, end_offset);
  end

  task automatic load_config(input logic [31:0] wo, input logic [31:0] ff,
                             input logic [31:0] fe);
    cfg_write <= 1'b1;
    cfg_index <= CFG_WINDOW_OFFSET;
    cfg_data  <= wo;
    @(posedge clk);
    cfg_index <= CFG_FUNCTION_FIRST;
    cfg_data  <= ff;
    @(posedge clk);
    cfg_index <= CFG_FUNCTION_END;
    cfg_data  <= fe;
    @(posedge clk);
    cfg_write <= 1'b0;
    tracker.set_register(CFG_WINDOW_OFFSET, wo);
    tracker.set_register(CFG_FUNCTION_FIRST, ff);
    tracker.set_register(CFG_FUNCTION_END, fe);
    settings++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    bit taken;
    code_valid <= 1'b1;
    code_byte  <= b;
    last_byte  <= last;
    do begin
      @(negedge clk);
      taken = !code_stall;
      @(posedge clk);
    end while (!taken);
    bytes_sent++;
    tracker.take_byte(b, last);
  endtask

  task automatic idle_cycles(input int unsigned n);
    code_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_window();
    foreach (win_bytes[i]) begin
      if (gaps_on && burst_left == 0) begin
        idle_cycles($urandom_range(1, 6));
        burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      send_byte(win_bytes[i], i == win_bytes.size() - 1);
    end
    windows_sent++;
  endtask

  // hold off code requests until every verdict is in and the pipe is quiet
  task automatic settle();
    code_valid <= 1'b0;
    while (tracker.verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_pop(input bit rex_ok);
    if (rex_ok && $urandom_range(0, 2) == 0) win_bytes.push_back(8'h40 | 8'($urandom_range(0, 15)));
    win_bytes.push_back(OPC_POP_FIRST + 8'($urandom_range(0, 7)));
  endtask

  task automatic push_random(input int unsigned n);
    repeat (n) win_bytes.push_back(8'($urandom));
  endtask

  task automatic add_head();
    logic [2:0] rm;
    rm = 3'($urandom_range(0, 6));
    if (rm >= REG_RSP) rm = rm + 3'd1;
    case ($urandom_range(0, 7))
      2: begin
        win_bytes.push_back(REX_W);
        win_bytes.push_back(OPC_ADD_IMM32);
        win_bytes.push_back(MODRM_RSP);
        push_random(4);
      end
      3: begin
        win_bytes.push_back(REX_W);
        win_bytes.push_back(OPC_ADD_IMM8);
        win_bytes.push_back(MODRM_RSP);
        push_random(1);
      end
      4, 5: begin
        win_bytes.push_back($urandom_range(0, 1) ? 8'h49 : REX_W);
        win_bytes.push_back(OPC_LEA);
        if ($urandom_range(0, 1)) begin
          win_bytes.push_back({MOD_DISP8, REG_RSP, rm});
          push_random(1);
        end else begin
          win_bytes.push_back({MOD_DISP32, REG_RSP, rm});
          push_random(4);
        end
      end
      6: begin
        // malformed stack adjustment
        win_bytes.push_back(REX_W | 8'($urandom_range(0, 7)));
        case ($urandom_range(0, 2))
          0: win_bytes.push_back(OPC_ADD_IMM32);
          1: win_bytes.push_back(OPC_ADD_IMM8);
          default: win_bytes.push_back(OPC_LEA);
        endcase
        push_random(2);
      end
      default: ;
    endcase
  endtask

  task automatic add_tail_jump();
    logic [31:0] rel;
    while (win_bytes.size() + 5 < jump_span) push_pop(win_bytes.size() + 6 < jump_span);
    case ($urandom_range(0, 3))
      0: rel = $urandom_range(0, 4096);
      1: rel = -$urandom_range(1, jump_span + 8);
      2: rel = $urandom;
      default: rel = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
    win_bytes.push_back(OPC_JMP_REL32);
    for (int i = 0; i < 4; i++) win_bytes.push_back(rel[8*i +: 8]);
  endtask

  task automatic make_window();
    int unsigned sel;
    int unsigned cut;
    win_bytes.delete();
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      push_random($urandom_range(1, 10));
    end else begin
      add_head();
      case ($urandom_range(0, 7))
        0, 1: begin
          repeat ($urandom_range(0, 4)) push_pop(1);
          win_bytes.push_back(OPC_RET);
        end
        2: begin
          repeat ($urandom_range(0, 4)) push_pop(1);
          win_bytes.push_back(OPC_RET_IMM);
          push_random(2);
        end
        3: begin
          repeat ($urandom_range(0, 4)) push_pop(1);
          win_bytes.push_back(OPC_REP);
          win_bytes.push_back($urandom_range(0, 2) ? OPC_RET : 8'($urandom));
        end
        4, 5, 6: add_tail_jump();
        default: begin
          repeat ($urandom_range(0, 4)) push_pop(1);
          push_random(1);
        end
      endcase
      push_random($urandom_range(0, 4));
      if (sel < 30) begin
        cut = $urandom_range(1, win_bytes.size());
        while (win_bytes.size() > cut) void'(win_bytes.pop_back());
      end
    end
  endtask

  initial begin
    #4_000_000;
    $display("FAIL x64_epilog_recognizer");
    $finish;
  end

  initial begin
    logic [31:0] wo;
    logic [31:0] ff;
    logic [31:0] fe;
    int unsigned goal;
    int unsigned phase_goal;
    int unsigned phase_no;

    tracker = new(WIN_BYTES);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_config(32'h0000_1000, 32'h0000_0F00, 32'h0000_1005);
    win_bytes = '{OPC_RET};
    send_window();
    win_bytes = '{8'h58, 8'h41, 8'h5F, OPC_RET};
    send_window();
    win_bytes = '{REX_W, OPC_ADD_IMM8, MODRM_RSP, 8'h28, OPC_REP, OPC_RET};
    send_window();
    win_bytes = '{REX_W, OPC_ADD_IMM32, 8'hC5, 8'h00};
    send_window();
    win_bytes = '{OPC_RET_IMM, 8'h08, 8'h00, 8'h90};
    send_window();
    win_bytes = '{OPC_JMP_REL32, 8'h10, 8'h00, 8'h00, 8'h00};
    send_window();
    win_bytes = '{8'h49, OPC_LEA, 8'h65, 8'h08, OPC_RET};
    send_window();
    settle();

    goal = 1200;
    for (phase_no = 0; bytes_sent < goal; phase_no++) begin
      case (phase_no)
        0: begin wo = '0; ff = '0; fe = '0; end
        1: begin wo = '1; ff = '1; fe = '1; end
        2: begin wo = 32'hFFFF_FFF0; ff = '0; fe = wo + 32'd20; end
        3: begin wo = '0; ff = '0; fe = 32'd10; end
        default: begin
          wo = $urandom;
          fe = wo + $urandom_range(5, 24);
          ff = ($urandom_range(0, 3) == 0) ? $urandom : wo - $urandom_range(0, 256);
        end
      endcase
      load_config(wo, ff, fe);
      jump_span = (fe - wo >= 5 && fe - wo <= 40) ? fe - wo : 8;
      gaps_on   = (phase_no % 3 != 1);
      if (phase_no == 3 || phase_no == 7) begin
        win_bytes.delete();
        repeat ($urandom_range(256, 264)) push_pop(0);
        win_bytes.push_back(OPC_RET);
        send_window();
      end
      phase_goal = bytes_sent + 100;
      while (bytes_sent < phase_goal && bytes_sent < goal) begin
        make_window();
        send_window();
        if ($urandom_range(0, 19) == 0) settle();
      end
      settle();
    end

    settle();
    repeat (8) @(posedge clk);
    $display("Covered %0d windows, %0d code bytes (%0d decoded), %0d register settings",
             windows_sent, bytes_sent, tracker.decoded_bytes, settings);
    $display("Verdicts: ret %0d, rep ret %0d, tail jump %0d, rejected %0d, window end %0d",
             tracker.kind_seen[0], tracker.kind_seen[1], tracker.kind_seen[2],
             tracker.kind_seen[3], tracker.kind_seen[4]);
    if (tracker.errors == 0) begin
      $display("PASS x64_epilog_recognizer");
    end else begin
      $display("FAIL x64_epilog_recognizer");
    end
    $finish;
  end

endmodule

### files.f
sv/x64ep_pkg.sv
sv/x64_epilog_recognizer.sv
sv/x64ep_checker.sv
bench/epilog_tracker_pkg.sv
bench/testbench.sv
